/* src/assert_macros.svh */
// -----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent assertions in the RTL.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define ASSERT_CLKED(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the standard clk_i / rst_ni pair of the module.
`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_CLKED(lbl, clk_i, rst_ni, prop, msg)

`endif

/* src/tdsd_pkg.sv */
// -----------------------------------------------------------------------------
// tdsd_pkg
// Types, constants and font/remap functions of the two-digit display control.
// -----------------------------------------------------------------------------
package tdsd_pkg;

  localparam int unsigned SCROLL_DEPTH_DEF = 64;
  localparam int unsigned CHAR_W           = 8;
  localparam int unsigned ACTION_W         = 3;
  localparam int unsigned IN_TDATA_W       = 16;
  localparam int unsigned IN_TUSER_W       = 4;
  localparam int unsigned PADDR_W          = 4;
  localparam int unsigned PDATA_W          = 32;
  localparam int unsigned MAP_W            = 24;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0]        SEG_B      = 8'h02;
  localparam logic [7:0]        SEG_DP     = 8'h80;

  localparam logic [15:0]      BLINK_PERIOD_RST    = 16'd1000;
  localparam logic [15:0]      SCROLL_INTERVAL_RST = 16'd300;
  localparam logic             ACTIVE_LOW_RST      = 1'b1;
  localparam logic [MAP_W-1:0] SEGMENT_MAP_RST     = 24'd16434824;

  // Register indexes (byte address / 4).
  localparam logic [1:0] REG_BLINK_PERIOD    = 2'd0;
  localparam logic [1:0] REG_SCROLL_INTERVAL = 2'd1;
  localparam logic [1:0] REG_ACTIVE_LOW      = 2'd2;
  localparam logic [1:0] REG_SEGMENT_MAP     = 2'd3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SET_PAIR    = 3'd0,
    ACT_LOAD_SCROLL = 3'd1,
    ACT_START_BLINK = 3'd2,
    ACT_STOP_BLINK  = 3'd3,
    ACT_TICK        = 3'd4,
    ACT_REFRESH     = 3'd5,
    ACT_STOP_SCROLL = 3'd6
  } action_e;

  typedef enum logic [2:0] {
    CMD_SET_PAIR,
    CMD_LOAD,
    CMD_START_BLINK,
    CMD_STOP_BLINK,
    CMD_TICK,
    CMD_REFRESH,
    CMD_STOP_SCROLL
  } cmd_e;

  typedef enum logic {
    BK_RUN,
    BK_FETCH
  } back_state_e;

  typedef struct packed {
    cmd_e              kind;
    logic [CHAR_W-1:0] char_a;
    logic [CHAR_W-1:0] char_b;
    logic              first_str;
    logic              end_str;
  } cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0] left;
    logic [CHAR_W-1:0] right;
  } pair_t;

  typedef struct packed {
    logic [15:0]      blink_period;
    logic [15:0]      scroll_interval;
    logic             active_low;
    logic [MAP_W-1:0] segment_map;
  } cfg_t;

  // Font: logical segments A..G,DP at bits 0..7.
  function automatic logic [7:0] glyph(input logic [CHAR_W-1:0] ch);
    logic [7:0] g;
    case (ch)
      8'h30, 8'h4F:        g = 8'h3F;  // 0 O
      8'h31, 8'h49, 8'h69: g = 8'h06;  // 1 I i
      8'h32, 8'h5A, 8'h7A: g = 8'h5B;  // 2 Z z
      8'h33:               g = 8'h4F;  // 3
      8'h34:               g = 8'h66;  // 4
      8'h35, 8'h53, 8'h73: g = 8'h6D;  // 5 S s
      8'h36, 8'h47, 8'h67: g = 8'h7D;  // 6 G g
      8'h37:               g = 8'h07;  // 7
      8'h38:               g = 8'h7F;  // 8
      8'h39:               g = 8'h6F;  // 9
      8'h41, 8'h61:        g = 8'h77;  // A a
      8'h42, 8'h62:        g = 8'h7C;  // B b
      8'h43:               g = 8'h39;  // C
      8'h44, 8'h64:        g = 8'h5E;  // D d
      8'h45, 8'h65:        g = 8'h79;  // E e
      8'h46, 8'h66:        g = 8'h71;  // F f
      8'h48:               g = 8'h76;  // H
      8'h4A, 8'h6A:        g = 8'h1E;  // J j
      8'h4C, 8'h6C:        g = 8'h38;  // L l
      8'h4E, 8'h6E:        g = 8'h54;  // N n
      8'h50, 8'h70:        g = 8'h73;  // P p
      8'h51, 8'h71:        g = 8'h67;  // Q q
      8'h52, 8'h72:        g = 8'h50;  // R r
      8'h54, 8'h74:        g = 8'h78;  // T t
      8'h55:               g = 8'h3E;  // U
      8'h56, 8'h76, 8'h75: g = 8'h1C;  // V v u
      8'h59, 8'h79:        g = 8'h6E;  // Y y
      8'h63:               g = 8'h58;  // c
      8'h68:               g = 8'h74;  // h
      8'h6F:               g = 8'h5C;  // o
      8'h21:               g = SEG_B | SEG_DP;  // !
      8'h2D:               g = 8'h40;  // -
      8'h5F:               g = 8'h08;  // _
      8'h2E:               g = 8'h80;  // .
      default:             g = 8'h00;
    endcase
    return g;
  endfunction

  // Move each logical segment to its mapped output bit and apply polarity.
  function automatic logic [7:0] to_raw(input logic [7:0] logical,
                                        input logic [MAP_W-1:0] seg_map,
                                        input logic active_low);
    logic [7:0] raw;
    logic [2:0] pos;
    raw = active_low ? 8'hFF : 8'h00;
    for (int s = 0; s < 8; s++) begin
      pos = seg_map[3*s +: 3];
      if (logical[s]) begin
        raw[pos] = ~active_low;
      end
    end
    return raw;
  endfunction

endpackage

/* src/tdsd_front.sv */
// -----------------------------------------------------------------------------
// tdsd_front
// Accepts input items; each known one becomes a resolved command for the queue.
// -----------------------------------------------------------------------------
module tdsd_front (
  input  logic                             s_valid_i,
  output logic                             s_ready_o,
  input  logic [tdsd_pkg::IN_TDATA_W-1:0]  s_tdata_i,
  input  logic [tdsd_pkg::IN_TUSER_W-1:0]  s_tuser_i,
  input  logic                             s_tlast_i,
  output logic                             push_o,
  output tdsd_pkg::cmd_t                   cmd_o,
  input  logic                             q_ready_i
);

  logic [tdsd_pkg::CHAR_W-1:0] c1;
  logic [tdsd_pkg::CHAR_W-1:0] c2;
  logic [tdsd_pkg::CHAR_W-1:0] c2_or_space;
  logic                        known;

  assign c1          = s_tdata_i[7:0];
  assign c2          = s_tdata_i[15:8];
  assign c2_or_space = (c2 != '0) ? c2 : tdsd_pkg::SPACE_CHAR;

  assign s_ready_o = q_ready_i;
  assign push_o    = s_valid_i && q_ready_i && known;

  // Empty characters are resolved here so the back end stores display-ready
  // characters only.
  always_comb begin
    known           = 1'b1;
    cmd_o.kind      = tdsd_pkg::CMD_TICK;
    cmd_o.char_a    = c1;
    cmd_o.char_b    = c2_or_space;
    cmd_o.first_str = s_tuser_i[3];
    cmd_o.end_str   = s_tlast_i;
    case (tdsd_pkg::action_e'(s_tuser_i[2:0]))
      tdsd_pkg::ACT_SET_PAIR: begin
        cmd_o.kind = tdsd_pkg::CMD_SET_PAIR;
        if (c1 == '0) begin
          cmd_o.char_a = tdsd_pkg::SPACE_CHAR;
          cmd_o.char_b = tdsd_pkg::SPACE_CHAR;
        end
      end
      tdsd_pkg::ACT_LOAD_SCROLL: cmd_o.kind = tdsd_pkg::CMD_LOAD;
      tdsd_pkg::ACT_START_BLINK: begin
        cmd_o.kind = (c1 == '0) ? tdsd_pkg::CMD_STOP_BLINK : tdsd_pkg::CMD_START_BLINK;
      end
      tdsd_pkg::ACT_STOP_BLINK:  cmd_o.kind = tdsd_pkg::CMD_STOP_BLINK;
      tdsd_pkg::ACT_TICK:        cmd_o.kind = tdsd_pkg::CMD_TICK;
      tdsd_pkg::ACT_REFRESH:     cmd_o.kind = tdsd_pkg::CMD_REFRESH;
      tdsd_pkg::ACT_STOP_SCROLL: cmd_o.kind = tdsd_pkg::CMD_STOP_SCROLL;
      default:                   known = 1'b0;
    endcase
  end

endmodule

/* src/tdsd_queue.sv */
// -----------------------------------------------------------------------------
// tdsd_queue
// Two-entry command queue between the front and back ends.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module tdsd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tdsd_pkg::cmd_t cmd_i,
  output logic           ready_o,
  output logic           valid_o,
  output tdsd_pkg::cmd_t cmd_o,
  input  logic           pop_i
);

  tdsd_pkg::cmd_t                  entry_q [tdsd_pkg::QUEUE_DEPTH];
  logic [tdsd_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [tdsd_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [tdsd_pkg::QCNT_W-1:0]     cnt_q, cnt_d;
  logic                            do_push;
  logic                            do_pop;

  assign ready_o = (cnt_q != tdsd_pkg::QCNT_W'(tdsd_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  `ASSERT_STD(a_q_count_bound, cnt_q <= tdsd_pkg::QCNT_W'(tdsd_pkg::QUEUE_DEPTH), "queue overfilled")

endmodule

/* src/tdsd_back.sv */
// -----------------------------------------------------------------------------
// tdsd_back
// Executes commands: shown pair, blink and scroll state, scroll string store.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module tdsd_back #(
  parameter int unsigned SCROLL_DEPTH = tdsd_pkg::SCROLL_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tdsd_pkg::cfg_t cfg_i,
  input  logic           cmd_valid_i,
  input  tdsd_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           pair_valid_o,
  output tdsd_pkg::pair_t pair_o,
  input  logic           pair_ready_i
);

  localparam int unsigned IDX_W = $clog2(SCROLL_DEPTH);
  localparam int unsigned LEN_W = $clog2(SCROLL_DEPTH + 1);
  localparam int unsigned POS_W = $clog2(SCROLL_DEPTH + 2);

  // Result of a store read that is applied to the shown pair in the next cycle.
  typedef struct packed {
    logic                        l_ok;
    logic                        r_ok;
    logic                        l_byp;
    logic                        r_byp;
    logic [tdsd_pkg::CHAR_W-1:0] byp_char;
  } fetch_t;

  tdsd_pkg::back_state_e state_q, state_d;
  fetch_t                fetch_q, fetch_d;

  logic [7:0]  shown_l_q, shown_l_d, shown_r_q, shown_r_d;
  logic        blink_on_q, blink_on_d, blink_vis_q, blink_vis_d;
  logic [7:0]  blink_a_q, blink_a_d, blink_b_q, blink_b_d;
  logic [15:0] blink_el_q, blink_el_d;
  logic        scroll_on_q, scroll_on_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0] scroll_el_q, scroll_el_d;

  logic [7:0]       store_q [SCROLL_DEPTH];
  logic [7:0]       rd0_q, rd1_q;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx, rd0_idx, rd1_idx;

  logic [15:0]      half;
  logic [15:0]      blink_inc, scroll_inc;
  logic [POS_W-1:0] len_ext, pos_wrap, pos_next;
  logic [LEN_W-1:0] len_base, len_new;
  logic             append;

  assign half       = (cfg_i.blink_period[15:1] == '0) ? 16'd1 : {1'b0, cfg_i.blink_period[15:1]};
  assign blink_inc  = (blink_el_q == 16'hFFFF) ? blink_el_q : blink_el_q + 16'd1;
  assign scroll_inc = (scroll_el_q == 16'hFFFF) ? scroll_el_q : scroll_el_q + 16'd1;
  assign len_ext    = POS_W'(len_q);
  assign pos_wrap   = (pos_q > len_ext) ? '0 : pos_q;
  assign pos_next   = pos_wrap + 1'b1;
  assign len_base   = cmd_i.first_str ? '0 : len_q;
  assign append     = (cmd_i.char_a != '0) && (len_base < LEN_W'(SCROLL_DEPTH));
  assign len_new    = append ? len_base + 1'b1 : len_base;

  always_comb begin
    state_d      = state_q;
    fetch_d      = fetch_q;
    shown_l_d    = shown_l_q;
    shown_r_d    = shown_r_q;
    blink_on_d   = blink_on_q;
    blink_vis_d  = blink_vis_q;
    blink_a_d    = blink_a_q;
    blink_b_d    = blink_b_q;
    blink_el_d   = blink_el_q;
    scroll_on_d  = scroll_on_q;
    len_d        = len_q;
    pos_d        = pos_q;
    scroll_el_d  = scroll_el_q;
    wr_en        = 1'b0;
    wr_idx       = len_base[IDX_W-1:0];
    rd0_idx      = pos_wrap[IDX_W-1:0];
    rd1_idx      = pos_next[IDX_W-1:0];
    cmd_pop_o    = 1'b0;
    pair_valid_o = 1'b0;
    pair_o.left  = shown_l_q;
    pair_o.right = shown_r_q;
    if (blink_on_q) begin
      pair_o.left  = blink_vis_q ? blink_a_q : tdsd_pkg::SPACE_CHAR;
      pair_o.right = blink_vis_q ? blink_b_q : tdsd_pkg::SPACE_CHAR;
    end

    case (state_q)
      tdsd_pkg::BK_RUN: begin
        if (cmd_valid_i && (cmd_i.kind != tdsd_pkg::CMD_REFRESH || pair_ready_i)) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            tdsd_pkg::CMD_SET_PAIR: begin
              shown_l_d = cmd_i.char_a;
              shown_r_d = cmd_i.char_b;
            end
            tdsd_pkg::CMD_LOAD: begin
              if (cmd_i.first_str) begin
                scroll_on_d = 1'b0;
              end
              wr_en = append;
              len_d = len_new;
              if (cmd_i.end_str) begin
                pos_d       = '0;
                scroll_el_d = '0;
                scroll_on_d = (len_new > LEN_W'(2));
                if (len_new <= LEN_W'(2)) begin
                  // Show the first two characters directly; a character
                  // written this cycle is taken from the bypass.
                  rd0_idx = '0;
                  rd1_idx = IDX_W'(1);
                  fetch_d.l_ok     = (len_new >= LEN_W'(1));
                  fetch_d.r_ok     = (len_new >= LEN_W'(2));
                  fetch_d.l_byp    = append && (len_base == '0);
                  fetch_d.r_byp    = append && (len_base == LEN_W'(1));
                  fetch_d.byp_char = cmd_i.char_a;
                  state_d          = tdsd_pkg::BK_FETCH;
                end
              end
            end
            tdsd_pkg::CMD_START_BLINK: begin
              blink_a_d   = cmd_i.char_a;
              blink_b_d   = cmd_i.char_b;
              blink_on_d  = 1'b1;
              blink_vis_d = 1'b1;
              blink_el_d  = '0;
            end
            tdsd_pkg::CMD_STOP_BLINK: begin
              blink_on_d  = 1'b0;
              blink_vis_d = 1'b1;
              blink_a_d   = '0;
              blink_b_d   = '0;
            end
            tdsd_pkg::CMD_TICK: begin
              if (blink_on_q) begin
                if (blink_inc >= half) begin
                  blink_el_d  = '0;
                  blink_vis_d = ~blink_vis_q;
                end else begin
                  blink_el_d = blink_inc;
                end
              end
              if (scroll_on_q) begin
                if (scroll_inc < cfg_i.scroll_interval) begin
                  scroll_el_d = scroll_inc;
                end else begin
                  scroll_el_d = '0;
                  if (len_q == '0) begin
                    shown_l_d = tdsd_pkg::SPACE_CHAR;
                    shown_r_d = tdsd_pkg::SPACE_CHAR;
                  end else begin
                    fetch_d.l_ok     = (pos_wrap < len_ext);
                    fetch_d.r_ok     = (pos_next < len_ext);
                    fetch_d.l_byp    = 1'b0;
                    fetch_d.r_byp    = 1'b0;
                    fetch_d.byp_char = '0;
                    pos_d            = pos_next;
                    state_d          = tdsd_pkg::BK_FETCH;
                  end
                end
              end
            end
            tdsd_pkg::CMD_REFRESH:     pair_valid_o = 1'b1;
            tdsd_pkg::CMD_STOP_SCROLL: scroll_on_d = 1'b0;
            default: ;
          endcase
        end
      end
      tdsd_pkg::BK_FETCH: begin
        shown_l_d = !fetch_q.l_ok ? tdsd_pkg::SPACE_CHAR :
                    (fetch_q.l_byp ? fetch_q.byp_char : rd0_q);
        shown_r_d = !fetch_q.r_ok ? tdsd_pkg::SPACE_CHAR :
                    (fetch_q.r_byp ? fetch_q.byp_char : rd1_q);
        state_d   = tdsd_pkg::BK_RUN;
      end
      default: state_d = tdsd_pkg::BK_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tdsd_pkg::BK_RUN;
      shown_l_q   <= tdsd_pkg::SPACE_CHAR;
      shown_r_q   <= tdsd_pkg::SPACE_CHAR;
      blink_on_q  <= 1'b0;
      blink_vis_q <= 1'b1;
      blink_a_q   <= '0;
      blink_b_q   <= '0;
      blink_el_q  <= '0;
      scroll_on_q <= 1'b0;
      len_q       <= '0;
      pos_q       <= '0;
      scroll_el_q <= '0;
    end else begin
      state_q     <= state_d;
      shown_l_q   <= shown_l_d;
      shown_r_q   <= shown_r_d;
      blink_on_q  <= blink_on_d;
      blink_vis_q <= blink_vis_d;
      blink_a_q   <= blink_a_d;
      blink_b_q   <= blink_b_d;
      blink_el_q  <= blink_el_d;
      scroll_on_q <= scroll_on_d;
      len_q       <= len_d;
      pos_q       <= pos_d;
      scroll_el_q <= scroll_el_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fetch_q <= fetch_d;
  end

  // Scroll string store: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_idx] <= cmd_i.char_a;
    end
  end

  always_ff @(posedge clk_i) begin
    rd0_q <= store_q[rd0_idx];
    rd1_q <= store_q[rd1_idx];
  end

  `ASSERT_STD(a_len_bound, len_q <= LEN_W'(SCROLL_DEPTH), "scroll length beyond store depth")
  `ASSERT_STD(a_fetch_single, state_q == tdsd_pkg::BK_FETCH |=> state_q == tdsd_pkg::BK_RUN, "fetch state held")
  `ASSERT_STD(a_no_pop_fetch, state_q == tdsd_pkg::BK_FETCH |-> !cmd_pop_o, "command taken during fetch")

endmodule

/* src/tdsd_slicer.sv */
// -----------------------------------------------------------------------------
// tdsd_slicer
// Decodes a character pair to raw segment bytes and emits left then right.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module tdsd_slicer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tdsd_pkg::cfg_t  cfg_i,
  input  logic            pair_valid_i,
  input  tdsd_pkg::pair_t pair_i,
  output logic            pair_ready_o,
  output logic            m_tvalid_o,
  input  logic            m_tready_i,
  output logic [7:0]      m_tdata_o,
  output logic            m_tuser_o,
  output logic            m_tlast_o
);

  logic [1:0] cnt_q, cnt_d;
  logic [7:0] left_q, right_q;
  logic       pair_fire;
  logic       out_fire;

  assign pair_ready_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_tready_i);
  assign pair_fire    = pair_valid_i && pair_ready_o;
  assign out_fire     = m_tvalid_o && m_tready_i;

  assign m_tvalid_o = (cnt_q != 2'd0);
  assign m_tdata_o  = (cnt_q == 2'd2) ? left_q : right_q;
  assign m_tuser_o  = (cnt_q == 2'd1);
  assign m_tlast_o  = (cnt_q == 2'd1);

  always_comb begin
    cnt_d = cnt_q;
    if (pair_fire) begin
      cnt_d = 2'd2;
    end else if (out_fire) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pair_fire) begin
      left_q  <= tdsd_pkg::to_raw(tdsd_pkg::glyph(pair_i.left), cfg_i.segment_map,
                                  cfg_i.active_low);
      right_q <= tdsd_pkg::to_raw(tdsd_pkg::glyph(pair_i.right), cfg_i.segment_map,
                                  cfg_i.active_low);
    end
  end

  `ASSERT_STD(a_cnt_range, cnt_q != 2'd3, "slice count out of range")
  `ASSERT_STD(a_left_first, pair_fire |=> (m_tvalid_o && !m_tuser_o), "left slice not first")

endmodule

/* src/two_digit_segment_display_control_unit.sv */
// -----------------------------------------------------------------------------
// two_digit_segment_display_control_unit
// Two-digit seven-segment display controller: commands in, segment slices out.
// -----------------------------------------------------------------------------
// Usage:
//   Command items enter on the s_axis channel: tuser carries the action code
//   and the start-of-string flag, tdata the two characters, tlast the
//   end-of-string flag. Millisecond ticks are tick commands. Only a refresh
//   produces results: two items on m_axis, the left slice (tuser 0) and then
//   the right slice (tuser 1, tlast 1), each a raw byte for the shift register.
//   Timing: an accepted item lands in a two-entry command queue register and
//   executes from there once the execution stage is free. Most commands run
//   in the run state alone; a tick that steps the scroll window and an
//   end-of-string load with two or fewer characters pass through a fetch
//   state as well, since the scroll store read is registered. The left slice
//   of a refresh is loaded into the output stage when the refresh executes,
//   and the right slice follows once the left is taken; the output stage
//   takes the next refresh only when empty or as its right slice is taken.
//   If the receiver stalls, the output stage holds its slices and the next
//   refresh waits in execution; the commands queued behind it wait with it,
//   and once the queue fills tready drops.
//   Reset loads the register defaults and clears all display state; the
//   scroll store is not cleared and needs no clearing pass, since only
//   entries that were written are ever shown. The user must write registers
//   through the APB port only while the block is idle; it does not enforce this.
// -----------------------------------------------------------------------------
module two_digit_segment_display_control_unit #(
  parameter int unsigned SCROLL_DEPTH = tdsd_pkg::SCROLL_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Command channel.
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [tdsd_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,  // [7:0] first_char, [15:8] second_char
  input  logic [tdsd_pkg::IN_TUSER_W-1:0] s_axis_tuser_i,  // [2:0] action, [3] first_of_string
  input  logic                            s_axis_tlast_i,  // end_of_string
  // Slice channel.
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [7:0]                      m_axis_tdata_o,  // [7:0] segment_byte
  output logic                            m_axis_tuser_o,  // [0] digit_select
  output logic                            m_axis_tlast_o,  // last
  // Register port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tdsd_pkg::PADDR_W-1:0]    paddr,
  input  logic [tdsd_pkg::PDATA_W-1:0]    pwdata,
  output logic [tdsd_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);

  logic [15:0]                blink_period_q;
  logic [15:0]                scroll_interval_q;
  logic                       active_low_q;
  logic [tdsd_pkg::MAP_W-1:0] segment_map_q;
  logic                       reg_wr;
  logic [1:0]                 reg_idx;
  tdsd_pkg::cfg_t             cfg;

  logic            push;
  tdsd_pkg::cmd_t  front_cmd;
  logic            q_ready;
  logic            q_valid;
  tdsd_pkg::cmd_t  q_cmd;
  logic            q_pop;
  logic            pair_valid;
  tdsd_pkg::pair_t pair;
  logic            pair_ready;

  // Registers sit at byte addresses 0, 4, 8 and 12.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_period_q    <= tdsd_pkg::BLINK_PERIOD_RST;
      scroll_interval_q <= tdsd_pkg::SCROLL_INTERVAL_RST;
      active_low_q      <= tdsd_pkg::ACTIVE_LOW_RST;
      segment_map_q     <= tdsd_pkg::SEGMENT_MAP_RST;
    end else if (reg_wr) begin
      case (reg_idx)
        tdsd_pkg::REG_BLINK_PERIOD:    blink_period_q    <= pwdata[15:0];
        tdsd_pkg::REG_SCROLL_INTERVAL: scroll_interval_q <= pwdata[15:0];
        tdsd_pkg::REG_ACTIVE_LOW:      active_low_q      <= pwdata[0];
        tdsd_pkg::REG_SEGMENT_MAP:     segment_map_q     <= pwdata[tdsd_pkg::MAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tdsd_pkg::REG_BLINK_PERIOD:    prdata = {16'd0, blink_period_q};
      tdsd_pkg::REG_SCROLL_INTERVAL: prdata = {16'd0, scroll_interval_q};
      tdsd_pkg::REG_ACTIVE_LOW:      prdata = {31'd0, active_low_q};
      tdsd_pkg::REG_SEGMENT_MAP:     prdata = {8'd0, segment_map_q};
      default:                       prdata = '0;
    endcase
  end

  assign cfg.blink_period    = blink_period_q;
  assign cfg.scroll_interval = scroll_interval_q;
  assign cfg.active_low      = active_low_q;
  assign cfg.segment_map     = segment_map_q;

  tdsd_front u_front (
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_tdata_i (s_axis_tdata_i),
    .s_tuser_i (s_axis_tuser_i),
    .s_tlast_i (s_axis_tlast_i),
    .push_o    (push),
    .cmd_o     (front_cmd),
    .q_ready_i (q_ready)
  );

  tdsd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .cmd_o   (q_cmd),
    .pop_i   (q_pop)
  );

  tdsd_back #(
    .SCROLL_DEPTH (SCROLL_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_valid_i  (q_valid),
    .cmd_i        (q_cmd),
    .cmd_pop_o    (q_pop),
    .pair_valid_o (pair_valid),
    .pair_o       (pair),
    .pair_ready_i (pair_ready)
  );

  tdsd_slicer u_slicer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .pair_valid_i (pair_valid),
    .pair_i       (pair),
    .pair_ready_o (pair_ready),
    .m_tvalid_o   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready_i),
    .m_tdata_o    (m_axis_tdata_o),
    .m_tuser_o    (m_axis_tuser_o),
    .m_tlast_o    (m_axis_tlast_o)
  );

endmodule

/* sim/tdsd_slice_checker.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Slice checker for the two-digit display control
// Watches the command, slice and register channels, keeps its own copy of
// the display state, predicts the two slices of every refresh and compares
// each slice that leaves the block with the oldest prediction.
// -----------------------------------------------------------------------------
module tdsd_slice_checker #(
  parameter int unsigned SCROLL_DEPTH = tdsd_pkg::SCROLL_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_tvalid_i,
  input  logic        cmd_tready_i,
  input  logic [15:0] cmd_tdata_i,   // [7:0] first_char, [15:8] second_char
  input  logic [3:0]  cmd_tuser_i,   // [2:0] action, [3] first_of_string
  input  logic        cmd_tlast_i,   // end_of_string
  input  logic        slice_tvalid_i,
  input  logic        slice_tready_i,
  input  logic [7:0]  slice_tdata_i, // [7:0] segment_byte
  input  logic        slice_tuser_i, // [0] digit_select
  input  logic        slice_tlast_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          mismatches_o,
  output int          pending_o,
  output int          slices_o
);
  import tdsd_pkg::*;

  typedef struct packed {
    logic [7:0] seg;
    logic       digit;
    logic       last;
  } slice_t;

  slice_t want_q[$];
  int     errs = 0;
  int     seen = 0;

  // Register copies.
  logic [15:0]      cfg_blink;
  logic [15:0]      cfg_scroll;
  logic             cfg_act_low;
  logic [MAP_W-1:0] cfg_map;

  // Display state.
  logic [7:0]  shown_l, shown_r;
  logic        blinking, blink_vis;
  logic [7:0]  blink_l, blink_r;
  logic [15:0] blink_cnt;
  logic        scrolling;
  logic [7:0]  text_mem [SCROLL_DEPTH];
  int          text_len;
  int          window_pos;
  logic [15:0] scroll_cnt;

  // Font with segments A..G at bits 0..6 and the decimal point at bit 7.
  function automatic logic [7:0] font_code(input logic [7:0] ch);
    logic [7:0] f;
    case (ch)
      "0", "O":      f = 8'h3F;
      "1", "I", "i": f = 8'h06;
      "2", "Z", "z": f = 8'h5B;
      "3":           f = 8'h4F;
      "4":           f = 8'h66;
      "5", "S", "s": f = 8'h6D;
      "6", "G", "g": f = 8'h7D;
      "7":           f = 8'h07;
      "8":           f = 8'h7F;
      "9":           f = 8'h6F;
      "A", "a":      f = 8'h77;
      "B", "b":      f = 8'h7C;
      "C":           f = 8'h39;
      "c":           f = 8'h58;
      "D", "d":      f = 8'h5E;
      "E", "e":      f = 8'h79;
      "F", "f":      f = 8'h71;
      "H":           f = 8'h76;
      "h":           f = 8'h74;
      "J", "j":      f = 8'h1E;
      "L", "l":      f = 8'h38;
      "N", "n":      f = 8'h54;
      "o":           f = 8'h5C;
      "P", "p":      f = 8'h73;
      "Q", "q":      f = 8'h67;
      "R", "r":      f = 8'h50;
      "T", "t":      f = 8'h78;
      "U":           f = 8'h3E;
      "V", "v", "u": f = 8'h1C;
      "Y", "y":      f = 8'h6E;
      "!":           f = 8'h82;
      "-":           f = 8'h40;
      "_":           f = 8'h08;
      ".":           f = 8'h80;
      default:       f = 8'h00;
    endcase
    return f;
  endfunction

  // Collect the lit output bits first, then apply the polarity as a whole.
  function automatic logic [7:0] drive_byte(input logic [7:0] lit);
    logic [7:0] on_bits;
    on_bits = 8'h00;
    for (int s = 0; s < 8; s++) begin
      if (lit[s]) begin
        on_bits[cfg_map[3*s +: 3]] = 1'b1;
      end
    end
    return cfg_act_low ? ~on_bits : on_bits;
  endfunction

  function automatic logic [7:0] or_space(input logic [7:0] ch);
    return (ch != 8'h00) ? ch : SPACE_CHAR;
  endfunction

  task automatic halt_blink();
    blinking  = 1'b0;
    blink_vis = 1'b1;
    blink_l   = 8'h00;
    blink_r   = 8'h00;
  endtask

  task automatic expect_slice(input logic [7:0] ch, input logic right);
    slice_t s;
    s.seg   = drive_byte(font_code(ch));
    s.digit = right;
    s.last  = right;
    want_q.push_back(s);
  endtask

  task automatic report(input string what, input int got, input int want);
    if (errs < 100) begin
      $display("mismatch at %0t: %s, got %0h, expected %0h", $realtime, what, got, want);
    end
    errs++;
  endtask

  task automatic apply_command(input logic [2:0] act, input logic [7:0] c1,
                               input logic [7:0] c2, input logic first,
                               input logic fin);
    logic [15:0] half;
    logic [7:0]  l, r;
    case (act)
      ACT_SET_PAIR: begin
        shown_l = or_space(c1);
        shown_r = (c1 == 8'h00) ? SPACE_CHAR : or_space(c2);
      end
      ACT_LOAD_SCROLL: begin
        if (first) begin
          text_len  = 0;
          scrolling = 1'b0;
        end
        // Characters past the end of the store are dropped.
        if (c1 != 8'h00 && text_len < SCROLL_DEPTH) begin
          text_mem[text_len] = c1;
          text_len++;
        end
        if (fin) begin
          window_pos = 0;
          scroll_cnt = 16'd0;
          scrolling  = (text_len > 2);
          if (!scrolling) begin
            shown_l = (text_len >= 1) ? text_mem[0] : SPACE_CHAR;
            shown_r = (text_len >= 2) ? text_mem[1] : SPACE_CHAR;
          end
        end
      end
      ACT_START_BLINK: begin
        if (c1 == 8'h00) begin
          halt_blink();
        end else begin
          blinking  = 1'b1;
          blink_vis = 1'b1;
          blink_l   = c1;
          blink_r   = c2;
          blink_cnt = 16'd0;
        end
      end
      ACT_STOP_BLINK: halt_blink();
      ACT_TICK: begin
        if (blinking) begin
          half = cfg_blink >> 1;
          if (half == 16'd0) half = 16'd1;
          if (blink_cnt != 16'hFFFF) blink_cnt++;
          if (blink_cnt >= half) begin
            blink_cnt = 16'd0;
            blink_vis = ~blink_vis;
          end
        end
        if (scrolling) begin
          if (scroll_cnt != 16'hFFFF) scroll_cnt++;
          if (scroll_cnt >= cfg_scroll) begin
            scroll_cnt = 16'd0;
            if (text_len == 0) begin
              shown_l = SPACE_CHAR;
              shown_r = SPACE_CHAR;
            end else begin
              // The window runs one step past the end, then starts over.
              if (window_pos > text_len) window_pos = 0;
              shown_l = (window_pos < text_len) ? text_mem[window_pos] : SPACE_CHAR;
              shown_r = (window_pos + 1 < text_len) ? text_mem[window_pos + 1] : SPACE_CHAR;
              window_pos++;
            end
          end
        end
      end
      ACT_REFRESH: begin
        l = shown_l;
        r = shown_r;
        if (blinking) begin
          l = blink_vis ? or_space(blink_l) : SPACE_CHAR;
          r = blink_vis ? or_space(blink_r) : SPACE_CHAR;
        end
        expect_slice(l, 1'b0);
        expect_slice(r, 1'b1);
      end
      ACT_STOP_SCROLL: scrolling = 1'b0;
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    slice_t w;
    if (!rst_ni) begin
      cfg_blink   = BLINK_PERIOD_RST;
      cfg_scroll  = SCROLL_INTERVAL_RST;
      cfg_act_low = ACTIVE_LOW_RST;
      cfg_map     = SEGMENT_MAP_RST;
      shown_l     = SPACE_CHAR;
      shown_r     = SPACE_CHAR;
      halt_blink();
      blink_cnt   = 16'd0;
      scrolling   = 1'b0;
      text_len    = 0;
      window_pos  = 0;
      scroll_cnt  = 16'd0;
      want_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          REG_BLINK_PERIOD:    cfg_blink   = pwdata_i[15:0];
          REG_SCROLL_INTERVAL: cfg_scroll  = pwdata_i[15:0];
          REG_ACTIVE_LOW:      cfg_act_low = pwdata_i[0];
          REG_SEGMENT_MAP:     cfg_map     = pwdata_i[MAP_W-1:0];
          default: ;
        endcase
      end
      if (cmd_tvalid_i && cmd_tready_i) begin
        apply_command(cmd_tuser_i[2:0], cmd_tdata_i[7:0], cmd_tdata_i[15:8],
                      cmd_tuser_i[3], cmd_tlast_i);
      end
      if (slice_tvalid_i && slice_tready_i) begin
        seen++;
        if (want_q.size() == 0) begin
          report("slice with no refresh pending", int'(slice_tdata_i), 0);
        end else begin
          w = want_q.pop_front();
          if (slice_tdata_i != w.seg)
            report("segment byte", int'(slice_tdata_i), int'(w.seg));
          if (slice_tuser_i != w.digit)
            report("digit select", int'(slice_tuser_i), int'(w.digit));
          if (slice_tlast_i != w.last)
            report("last flag", int'(slice_tlast_i), int'(w.last));
        end
      end
    end
    pending_o    <= want_q.size();
    mismatches_o <= errs;
    slices_o     <= seen;
  end

endmodule

/* sim/two_digit_segment_display_control_unit_tb.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Testbench for two_digit_segment_display_control_unit
// Drives command items and register writes into the display control, stalls
// the slice receiver at random, and leaves prediction and comparison to the
// slice checker that sits beside the block.
// -----------------------------------------------------------------------------
module two_digit_segment_display_control_unit_tb;
  import tdsd_pkg::*;

  // Action code that the block must ignore.
  localparam logic [2:0] ACT_UNUSED = 3'd7;
  // Identity segment map: logical segment i on output bit i.
  localparam logic [MAP_W-1:0] MAP_IDENTITY = 24'hFAC688;
  // A quiet stretch in a correct run is at most a sender gap, a receiver
  // stall, the block latency and a register phase; the limit allows many
  // times that.
  localparam int QUIET_LIMIT = 2000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic        cmd_valid = 1'b0;
  logic        cmd_ready;
  logic [15:0] cmd_data  = 16'h0000;  // [7:0] first_char, [15:8] second_char
  logic [3:0]  cmd_user  = 4'h0;      // [2:0] action, [3] first_of_string
  logic        cmd_last  = 1'b0;      // end_of_string

  logic        slice_valid;
  logic        slice_ready = 1'b0;
  logic [7:0]  slice_data;            // [7:0] segment_byte
  logic        slice_user;            // [0] digit_select
  logic        slice_last;

  logic        apb_sel    = 1'b0;
  logic        apb_enable = 1'b0;
  logic        apb_write  = 1'b0;
  logic [3:0]  apb_addr   = 4'h0;
  logic [31:0] apb_wdata  = 32'h0;
  logic [31:0] apb_rdata;
  logic        apb_ready;

  int mismatches;
  int pending;
  int slices;

  // Commands sent (ignored codes not counted), register settings applied.
  int  sent     = 0;
  int  settings = 0;
  // Set for the last part of the run: no idling on either side.
  bit  calm     = 1'b0;
  int  quiet    = 0;

  string font_chars = "0123456789AaBbCcDdEeFfGgHhIiJjLlNnOoPpQqRrSsTtUuVvYyZz!-_.";

  always #6 clk_i = ~clk_i;

  two_digit_segment_display_control_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (cmd_valid),
    .s_axis_tready_o (cmd_ready),
    .s_axis_tdata_i  (cmd_data),
    .s_axis_tuser_i  (cmd_user),
    .s_axis_tlast_i  (cmd_last),
    .m_axis_tvalid_o (slice_valid),
    .m_axis_tready_i (slice_ready),
    .m_axis_tdata_o  (slice_data),
    .m_axis_tuser_o  (slice_user),
    .m_axis_tlast_o  (slice_last),
    .psel            (apb_sel),
    .penable         (apb_enable),
    .pwrite          (apb_write),
    .paddr           (apb_addr),
    .pwdata          (apb_wdata),
    .prdata          (apb_rdata),
    .pready          (apb_ready)
  );

  // The checker sees the same channels as the block and predicts from them.
  tdsd_slice_checker u_slice_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_tvalid_i   (cmd_valid),
    .cmd_tready_i   (cmd_ready),
    .cmd_tdata_i    (cmd_data),
    .cmd_tuser_i    (cmd_user),
    .cmd_tlast_i    (cmd_last),
    .slice_tvalid_i (slice_valid),
    .slice_tready_i (slice_ready),
    .slice_tdata_i  (slice_data),
    .slice_tuser_i  (slice_user),
    .slice_tlast_i  (slice_last),
    .psel_i         (apb_sel),
    .penable_i      (apb_enable),
    .pwrite_i       (apb_write),
    .pready_i       (apb_ready),
    .paddr_i        (apb_addr),
    .pwdata_i       (apb_wdata),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .slices_o       (slices)
  );

  // Mostly glyph characters, sometimes the empty code, sometimes any byte.
  function automatic logic [7:0] pick_char();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 8'h00;
    if (roll < 3) return 8'($urandom_range(0, 255));
    return font_chars[$urandom_range(0, font_chars.len() - 1)];
  endfunction

  // Sends one command item. Before it the sender may go idle for a burst;
  // valid stays high from one item to the next otherwise.
  task automatic send_cmd(input logic [2:0] act, input logic [7:0] c1,
                          input logic [7:0] c2, input logic first, input logic fin);
    if (!calm && $urandom_range(0, 7) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    cmd_valid <= 1'b1;
    cmd_data  <= {c2, c1};
    cmd_user  <= {first, act};
    cmd_last  <= fin;
    do @(posedge clk_i); while (!cmd_ready);
    if (act != ACT_UNUSED) sent++;
  endtask

  // A command whose character and flag fields carry nothing but noise.
  task automatic send_bare(input logic [2:0] act);
    send_cmd(act, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // Ticks with refreshes scattered among them, to watch blink and scroll move.
  task automatic tick_mix(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0) send_bare(ACT_REFRESH);
      else send_bare(ACT_TICK);
    end
  endtask

  // Stops sending and waits until every slice has come out, then gives
  // queued commands that produce nothing time to finish executing.
  task automatic settle();
    cmd_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready. psel is left
  // high so that writes can follow back to back.
  task automatic apb_put(input logic [1:0] idx, input logic [31:0] value);
    apb_sel    <= 1'b1;
    apb_enable <= 1'b0;
    apb_write  <= 1'b1;
    apb_addr   <= {idx, 2'b00};
    apb_wdata  <= value;
    @(posedge clk_i);
    apb_enable <= 1'b1;
    do @(posedge clk_i); while (!apb_ready);
  endtask

  task automatic write_setup(input logic [15:0] blink, input logic [15:0] step,
                             input logic act_low, input logic [MAP_W-1:0] seg_map);
    apb_put(REG_BLINK_PERIOD, {16'h0, blink});
    apb_put(REG_SCROLL_INTERVAL, {16'h0, step});
    apb_put(REG_ACTIVE_LOW, {31'h0, act_low});
    apb_put(REG_SEGMENT_MAP, {8'h0, seg_map});
    apb_sel    <= 1'b0;
    apb_enable <= 1'b0;
    apb_write  <= 1'b0;
    settings++;
  endtask

  // Random traffic. Most of it is well-formed: whole scroll strings followed
  // by ticks, blink sessions, pair updates with a refresh. The rest is noise
  // with every field random, which also yields broken strings.
  task automatic run_random(input int quota);
    int stop_at;
    int roll;
    int len;
    stop_at = sent + quota;
    while (sent < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        // Now and then a string near the store depth, on either side of it, so that it may overflow.
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          send_cmd(ACT_LOAD_SCROLL, pick_char(), 8'($urandom_range(0, 255)),
                   i == 0, i == len - 1);
        end
        tick_mix($urandom_range(2, 14));
        if ($urandom_range(0, 3) == 0) send_bare(ACT_STOP_SCROLL);
      end else if (roll < 50) begin
        send_cmd(ACT_START_BLINK, pick_char(), pick_char(),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        tick_mix($urandom_range(1, 10));
        if ($urandom_range(0, 2) == 0) send_bare(ACT_STOP_BLINK);
      end else if (roll < 65) begin
        send_cmd(ACT_SET_PAIR, pick_char(), pick_char(),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        send_bare(ACT_REFRESH);
      end else if (roll < 85) begin
        tick_mix($urandom_range(1, 6));
      end else begin
        send_bare(3'($urandom_range(0, 7)));
      end
    end
  endtask

  // Slice receiver: ready high, with stall bursts at random until the calm last part of the run.
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!calm && $urandom_range(0, 7) == 0) begin
        slice_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      slice_ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_valid && cmd_ready) || (slice_valid && slice_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The first refresh sees the reset pair and reset
    // registers; the rest runs with the shortest blink half period and a
    // scroll step on every tick.
    send_bare(ACT_REFRESH);
    settle();
    write_setup(16'd2, 16'd0, 1'b1, MAP_IDENTITY);
    // A character with no glyph beside the full eight.
    send_cmd(ACT_SET_PAIR, 8'hFF, "8", 1'b1, 1'b1);
    send_bare(ACT_REFRESH);
    // An empty left character blanks both digits.
    send_cmd(ACT_SET_PAIR, 8'h00, "A", 1'b0, 1'b0);
    // A missing right character shows as a space.
    send_cmd(ACT_SET_PAIR, "!", 8'h00, 1'b0, 1'b0);
    send_bare(ACT_REFRESH);
    // Blinking with no right character, visible and then dark.
    send_cmd(ACT_START_BLINK, "H", 8'h00, 1'b0, 1'b0);
    send_bare(ACT_REFRESH);
    send_bare(ACT_TICK);
    send_bare(ACT_REFRESH);
    // An empty start of blink stops it, as does the stop command.
    send_cmd(ACT_START_BLINK, 8'h00, "x", 1'b0, 1'b0);
    send_cmd(ACT_START_BLINK, "E", "-", 1'b0, 1'b0);
    send_bare(ACT_STOP_BLINK);
    // A three-character string with an empty character in it, scrolled
    // up to the step past its end.
    send_cmd(ACT_LOAD_SCROLL, ".", 8'hFF, 1'b1, 1'b0);
    send_cmd(ACT_LOAD_SCROLL, 8'h00, 8'hFF, 1'b0, 1'b0);
    send_cmd(ACT_LOAD_SCROLL, "_", 8'hFF, 1'b0, 1'b0);
    send_cmd(ACT_LOAD_SCROLL, "o", 8'hFF, 1'b0, 1'b1);
    repeat (4) send_bare(ACT_TICK);
    send_bare(ACT_REFRESH);
    send_bare(ACT_STOP_SCROLL);
    // An empty string shows spaces; a single character shows directly.
    send_cmd(ACT_LOAD_SCROLL, 8'h00, 8'h00, 1'b1, 1'b1);
    send_bare(ACT_REFRESH);
    send_cmd(ACT_LOAD_SCROLL, "7", 8'h00, 1'b1, 1'b1);
    send_bare(ACT_REFRESH);
    send_bare(ACT_UNUSED);

    // Random part in phases, each under its own register setting: first the
    // extremes, then short random periods with random maps.
    for (int p = 0; p < 7; p++) begin
      settle();
      case (p)
        0:       write_setup(16'd0, 16'd1, 1'b0, 24'h000000);
        1:       write_setup(16'd1, 16'd2, 1'b1, 24'hFFFFFF);
        2:       write_setup(16'hFFFF, 16'hFFFF, 1'b0, 24'($urandom_range(0, 24'hFFFFFF)));
        default: write_setup(16'($urandom_range(0, 12)), 16'($urandom_range(0, 6)),
                             1'($urandom_range(0, 1)), 24'($urandom_range(0, 24'hFFFFFF)));
      endcase
      if (p == 6) calm = 1'b1;
      run_random(140);
    end

    cmd_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("run summary: %0d commands under %0d register settings, %0d slices compared",
             sent, settings, slices);
    if (pending != 0) $display("%0d predicted slices never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/tdsd_pkg.sv
src/tdsd_front.sv
src/tdsd_queue.sv
src/tdsd_back.sv
src/tdsd_slicer.sv
src/two_digit_segment_display_control_unit.sv
sim/tdsd_slice_checker.sv
sim/two_digit_segment_display_control_unit_tb.sv
